// ===== rtl/csi_pkg.sv =====
// shared types, constants and decode codes for the csr system instruction unit
// no dependencies; used by every module under rtl
`default_nettype none

package csi_pkg;

  localparam int XLEN       = 64;
  localparam int CSR_ADDR_W = 12;
  localparam int CSR_DEPTH  = 4096;
  localparam int CSR_AW     = $clog2(CSR_DEPTH);
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);

  localparam logic [CSR_ADDR_W-1:0] A_USTATUS = 12'h000;
  localparam logic [CSR_ADDR_W-1:0] A_UEPC    = 12'h041;
  localparam logic [CSR_ADDR_W-1:0] A_SSTATUS = 12'h100;
  localparam logic [CSR_ADDR_W-1:0] A_SEPC    = 12'h141;
  localparam logic [CSR_ADDR_W-1:0] A_MSTATUS = 12'h300;
  localparam logic [CSR_ADDR_W-1:0] A_MEPC    = 12'h341;

  localparam logic [CSR_ADDR_W-1:0] SYS_ECALL  = 12'h000;
  localparam logic [CSR_ADDR_W-1:0] SYS_EBREAK = 12'h001;
  localparam logic [CSR_ADDR_W-1:0] SYS_URET   = 12'h002;
  localparam logic [CSR_ADDR_W-1:0] SYS_SRET   = 12'h102;
  localparam logic [CSR_ADDR_W-1:0] SYS_WFI    = 12'h105;
  localparam logic [CSR_ADDR_W-1:0] SYS_MRET   = 12'h302;

  localparam logic [2:0] F3_PRIV = 3'd0;
  localparam logic [2:0] F3_RSV  = 3'd4;

  localparam logic [1:0] PRIV_U = 2'd0;
  localparam logic [1:0] PRIV_S = 2'd1;
  localparam logic [1:0] PRIV_H = 2'd2;
  localparam logic [1:0] PRIV_M = 2'd3;

  localparam int ST_SIE  = 1;
  localparam int ST_MIE  = 3;
  localparam int ST_SPIE = 5;
  localparam int ST_MPIE = 7;
  localparam int ST_SPP  = 8;
  localparam int ST_MPP  = 11;

  typedef enum logic [2:0] {
    OP_CSR,
    OP_ILLEGAL,
    OP_ECALL,
    OP_EBREAK,
    OP_SRET,
    OP_MRET,
    OP_URET,
    OP_WFI
  } op_e;

  typedef enum logic [1:0] {
    FN_NONE  = 2'd0,
    FN_WRITE = 2'd1,
    FN_SET   = 2'd2,
    FN_CLEAR = 2'd3
  } csr_fn_e;

  typedef enum logic [2:0] {
    CAUSE_ILLEGAL = 3'd0,
    CAUSE_BREAK   = 3'd1,
    CAUSE_ECALL_U = 3'd2,
    CAUSE_ECALL_S = 3'd3,
    CAUSE_ECALL_M = 3'd4
  } cause_e;

  typedef enum logic [2:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_READ0,
    BS_READ1,
    BS_EXEC
  } back_state_e;

  typedef struct packed {
    op_e                   op;
    csr_fn_e               fn;
    logic [CSR_ADDR_W-1:0] addr;
    logic                  addr_ok;
    logic [4:0]            rd;
    logic [XLEN-1:0]       src;
  } item_t;

  typedef struct packed {
    logic            rd_write;
    logic [4:0]      rd_index;
    logic [XLEN-1:0] rd_value;
    logic            redirect;
    logic [XLEN-1:0] redirect_pc;
    logic            trap;
    cause_e          trap_cause;
    logic            wait_interrupt;
    logic [1:0]      priv_level;
    logic            xret_done;
  } res_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

`default_nettype wire

// ===== rtl/csi_front.sv =====
// front end: classifies a system instruction word into a queue item
// depends on csi_pkg
`default_nettype none

module csi_front (
  input  wire logic [31:0]                 instr_word_i,
  input  wire logic [csi_pkg::XLEN-1:0]    rs1_value_i,
  output csi_pkg::item_t                   item_o
);

  logic [2:0]                     f3;
  logic [4:0]                     uimm;
  logic [csi_pkg::CSR_ADDR_W-1:0] addr;

  assign f3   = instr_word_i[14:12];
  assign uimm = instr_word_i[19:15];
  assign addr = instr_word_i[31:20];

  always_comb begin
    item_o.addr    = addr;
    item_o.addr_ok = ((csi_pkg::CSR_ADDR_W + 1)'(addr)
                      < (csi_pkg::CSR_ADDR_W + 1)'(csi_pkg::CSR_DEPTH));
    item_o.rd      = instr_word_i[11:7];
    item_o.src     = f3[2] ? csi_pkg::XLEN'(uimm) : rs1_value_i;
    item_o.fn      = csi_pkg::FN_NONE;
    item_o.op      = csi_pkg::OP_ILLEGAL;
    if (f3 != csi_pkg::F3_PRIV) begin
      if (f3 != csi_pkg::F3_RSV) begin
        item_o.op = csi_pkg::OP_CSR;
        item_o.fn = csi_pkg::csr_fn_e'(f3[1:0]);
      end
    end else begin
      unique case (addr)
        csi_pkg::SYS_ECALL:  item_o.op = csi_pkg::OP_ECALL;
        csi_pkg::SYS_EBREAK: item_o.op = csi_pkg::OP_EBREAK;
        csi_pkg::SYS_SRET:   item_o.op = csi_pkg::OP_SRET;
        csi_pkg::SYS_MRET:   item_o.op = csi_pkg::OP_MRET;
        csi_pkg::SYS_URET:   item_o.op = csi_pkg::OP_URET;
        csi_pkg::SYS_WFI:    item_o.op = csi_pkg::OP_WFI;
        default:             item_o.op = csi_pkg::OP_ILLEGAL;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/csi_queue.sv =====
// short item queue between the front end and the execution back end
// depends on csi_pkg
`default_nettype none

module csi_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire csi_pkg::item_t item_i,
  input  wire logic          pop_i,
  output csi_pkg::item_t     item_o,
  output csi_pkg::q_status_t status_o
);

  csi_pkg::item_t                  ent_q [csi_pkg::Q_DEPTH];
  logic [csi_pkg::Q_PTR_W-1:0]     wptr_q, wptr_d, rptr_q, rptr_d;
  logic [csi_pkg::Q_PTR_W:0]       cnt_q, cnt_d;

  // depth is a power of two so the pointers wrap on their own
  always_comb begin
    wptr_d = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop_i ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= item_i;
    end
  end

  assign item_o         = ent_q[rptr_q];
  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == (csi_pkg::Q_PTR_W + 1)'(csi_pkg::Q_DEPTH));

endmodule

`default_nettype wire

// ===== rtl/csi_back.sv =====
// back end: csr memory, privilege register, sequencer and result register
// depends on csi_pkg
`default_nettype none

module csi_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire csi_pkg::q_status_t q_status_i,
  input  wire csi_pkg::item_t     q_item_i,
  output logic                    pop_o,
  output logic                    clearing_o,
  output logic                    done_o,
  output csi_pkg::res_t           res_o
);

  csi_pkg::back_state_e          state_q, state_d, first_state;
  logic [csi_pkg::CSR_AW-1:0]    clr_q, clr_d;
  csi_pkg::item_t                item_q;
  logic [csi_pkg::XLEN-1:0]      mem_q [csi_pkg::CSR_DEPTH];
  logic [csi_pkg::XLEN-1:0]      rdata_q, stat_q, old_val, new_val, st_new;
  logic [csi_pkg::CSR_AW-1:0]    raddr, waddr;
  logic [csi_pkg::XLEN-1:0]      wdata;
  logic                          we;
  logic [1:0]                    priv_q, priv_d, mpp;
  logic                          done_q, done_d;
  csi_pkg::res_t                 res_q, res_d;
  logic                          clr_last;

  assign clr_last = (clr_q == csi_pkg::CSR_AW'(csi_pkg::CSR_DEPTH - 1));

  always_comb begin
    unique case (q_item_i.op)
      csi_pkg::OP_CSR,
      csi_pkg::OP_SRET,
      csi_pkg::OP_MRET,
      csi_pkg::OP_URET: first_state = csi_pkg::BS_READ0;
      default:          first_state = csi_pkg::BS_EXEC;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      csi_pkg::BS_CLEAR: begin
        if (clr_last) state_d = csi_pkg::BS_IDLE;
      end
      csi_pkg::BS_IDLE,
      csi_pkg::BS_EXEC: begin
        state_d = q_status_i.empty ? csi_pkg::BS_IDLE : first_state;
      end
      csi_pkg::BS_READ0: begin
        state_d = (item_q.op == csi_pkg::OP_CSR) ? csi_pkg::BS_EXEC : csi_pkg::BS_READ1;
      end
      csi_pkg::BS_READ1: state_d = csi_pkg::BS_EXEC;
      default:           state_d = csi_pkg::BS_CLEAR;
    endcase
  end

  // datapath for the item in execution
  always_comb begin
    old_val = item_q.addr_ok ? rdata_q : '0;
    unique case (item_q.fn)
      csi_pkg::FN_SET:   new_val = old_val | item_q.src;
      csi_pkg::FN_CLEAR: new_val = old_val & ~item_q.src;
      default:           new_val = item_q.src;
    endcase
    mpp    = stat_q[csi_pkg::ST_MPP +: 2];
    st_new = stat_q;
    if (item_q.op == csi_pkg::OP_MRET) begin
      st_new[csi_pkg::ST_MPP +: 2] = 2'b00;
      st_new[csi_pkg::ST_MIE]      = stat_q[csi_pkg::ST_MPIE];
      st_new[csi_pkg::ST_MPIE]     = 1'b1;
    end else begin
      st_new[csi_pkg::ST_SIE]      = stat_q[csi_pkg::ST_SPIE];
      st_new[csi_pkg::ST_SPP]      = 1'b0;
      st_new[csi_pkg::ST_SPIE]     = 1'b1;
    end
  end

  // outputs of the sequencer
  always_comb begin
    pop_o      = 1'b0;
    clearing_o = 1'b0;
    clr_d      = clr_q;
    we         = 1'b0;
    waddr      = item_q.addr[csi_pkg::CSR_AW-1:0];
    wdata      = new_val;
    raddr      = item_q.addr[csi_pkg::CSR_AW-1:0];
    priv_d     = priv_q;
    done_d     = 1'b0;
    res_d      = res_q;
    unique case (state_q)
      csi_pkg::BS_CLEAR: begin
        clearing_o = 1'b1;
        we         = 1'b1;
        waddr      = clr_q;
        wdata      = '0;
        clr_d      = clr_q + 1'b1;
      end
      csi_pkg::BS_IDLE: begin
        pop_o = !q_status_i.empty;
      end
      csi_pkg::BS_READ0: begin
        unique case (item_q.op)
          csi_pkg::OP_SRET: raddr = csi_pkg::A_SSTATUS[csi_pkg::CSR_AW-1:0];
          csi_pkg::OP_MRET: raddr = csi_pkg::A_MSTATUS[csi_pkg::CSR_AW-1:0];
          csi_pkg::OP_URET: raddr = csi_pkg::A_USTATUS[csi_pkg::CSR_AW-1:0];
          default:          raddr = item_q.addr[csi_pkg::CSR_AW-1:0];
        endcase
      end
      csi_pkg::BS_READ1: begin
        unique case (item_q.op)
          csi_pkg::OP_SRET: raddr = csi_pkg::A_SEPC[csi_pkg::CSR_AW-1:0];
          csi_pkg::OP_MRET: raddr = csi_pkg::A_MEPC[csi_pkg::CSR_AW-1:0];
          default:          raddr = csi_pkg::A_UEPC[csi_pkg::CSR_AW-1:0];
        endcase
      end
      csi_pkg::BS_EXEC: begin
        pop_o  = !q_status_i.empty;
        done_d = 1'b1;
        res_d  = '0;
        unique case (item_q.op)
          csi_pkg::OP_CSR: begin
            we             = item_q.addr_ok;
            res_d.rd_write = 1'b1;
            res_d.rd_index = item_q.rd;
            res_d.rd_value = old_val;
          end
          csi_pkg::OP_ECALL: begin
            res_d.trap = 1'b1;
            if (priv_q == csi_pkg::PRIV_U) begin
              res_d.trap_cause = csi_pkg::CAUSE_ECALL_U;
            end else if (priv_q == csi_pkg::PRIV_S) begin
              res_d.trap_cause = csi_pkg::CAUSE_ECALL_S;
            end else begin
              res_d.trap_cause = csi_pkg::CAUSE_ECALL_M;
            end
          end
          csi_pkg::OP_EBREAK: begin
            res_d.trap       = 1'b1;
            res_d.trap_cause = csi_pkg::CAUSE_BREAK;
          end
          csi_pkg::OP_SRET: begin
            we                = 1'b1;
            waddr             = csi_pkg::A_SSTATUS[csi_pkg::CSR_AW-1:0];
            wdata             = st_new;
            priv_d            = {1'b0, stat_q[csi_pkg::ST_SPP]};
            res_d.redirect    = 1'b1;
            res_d.redirect_pc = rdata_q;
            res_d.xret_done   = 1'b1;
          end
          csi_pkg::OP_MRET: begin
            we                = 1'b1;
            waddr             = csi_pkg::A_MSTATUS[csi_pkg::CSR_AW-1:0];
            wdata             = st_new;
            priv_d            = (mpp == csi_pkg::PRIV_H) ? csi_pkg::PRIV_U : mpp;
            res_d.redirect    = 1'b1;
            res_d.redirect_pc = rdata_q;
            res_d.xret_done   = 1'b1;
          end
          csi_pkg::OP_URET: begin
            priv_d            = {1'b0, stat_q[csi_pkg::ST_SPP]};
            res_d.redirect    = 1'b1;
            res_d.redirect_pc = rdata_q;
            res_d.xret_done   = 1'b1;
          end
          csi_pkg::OP_WFI: begin
            res_d.wait_interrupt = 1'b1;
          end
          default: begin
            res_d.trap       = 1'b1;
            res_d.trap_cause = csi_pkg::CAUSE_ILLEGAL;
          end
        endcase
        res_d.priv_level = priv_d;
      end
      default: begin
        clearing_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csi_pkg::BS_CLEAR;
      clr_q   <= '0;
      priv_q  <= csi_pkg::PRIV_M;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      priv_q  <= priv_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= q_item_i;
    end
    if (state_q == csi_pkg::BS_READ1) begin
      stat_q <= rdata_q;
    end
    res_q <= res_d;
  end

  // csr memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

// ===== rtl/csr_system_instruction_unit_top.sv =====
// top level of the csr system instruction unit
// depends on csi_pkg, csi_front, csi_queue and csi_back
`default_nettype none

// An instruction is taken when start is high and busy is low; its result appears
// on the output ports, marked by done_o high for exactly one cycle, and cannot be
// held off. After reset the unit clears its 4096-entry csr memory one entry a
// cycle and keeps busy high while it clears. Items pass a two-entry queue into
// the execution stage, and the result is registered. The csr memory gives one
// registered read a cycle: csr read-modify-write instructions read once before
// they execute, sret, mret and uret read twice (status, then epc), and ecall,
// ebreak, wfi and illegal encodings execute with no read.
module csr_system_instruction_unit_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [31:0]               instr_word_i,
  input  wire logic [csi_pkg::XLEN-1:0]  rs1_value_i,
  output logic                           done_o,
  output logic                           rd_write_o,
  output logic [4:0]                     rd_index_o,
  output logic [csi_pkg::XLEN-1:0]       rd_value_o,
  output logic                           redirect_o,
  output logic [csi_pkg::XLEN-1:0]       redirect_pc_o,
  output logic                           trap_o,
  output logic [2:0]                     trap_cause_o,
  output logic                           wait_interrupt_o,
  output logic [1:0]                     priv_level_o,
  output logic                           xret_done_o
);

  csi_pkg::item_t     front_item, q_item;
  csi_pkg::q_status_t q_status;
  csi_pkg::res_t      res;
  logic               push, pop, clearing;

  assign busy = q_status.full || clearing;
  assign push = start && !busy;

  csi_front u_front (
    .instr_word_i (instr_word_i),
    .rs1_value_i  (rs1_value_i),
    .item_o       (front_item)
  );

  csi_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (front_item),
    .pop_i    (pop),
    .item_o   (q_item),
    .status_o (q_status)
  );

  csi_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .q_item_i   (q_item),
    .pop_o      (pop),
    .clearing_o (clearing),
    .done_o     (done_o),
    .res_o      (res)
  );

  assign rd_write_o       = res.rd_write;
  assign rd_index_o       = res.rd_index;
  assign rd_value_o       = res.rd_value;
  assign redirect_o       = res.redirect;
  assign redirect_pc_o    = res.redirect_pc;
  assign trap_o           = res.trap;
  assign trap_cause_o     = res.trap_cause;
  assign wait_interrupt_o = res.wait_interrupt;
  assign priv_level_o     = res.priv_level;
  assign xret_done_o      = res.xret_done;

  a_csr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rd_write_o |-> !trap_o && !redirect_o && !wait_interrupt_o)
    else $error("csr result with trap, redirect or wait");

  a_xret_redirect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (xret_done_o == redirect_o))
    else $error("return without redirect");

  a_cause_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !trap_o |-> trap_cause_o == 3'(csi_pkg::CAUSE_ILLEGAL))
    else $error("trap cause without trap");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty && !clearing)
    else $error("pop from empty queue or during clear");

endmodule

`default_nettype wire
